// ----- sv/gte_pkg.sv -----
//------------------------------------------------------------------------------
// gte_pkg
// Shared constants, command and status codes, controller operations and the
// status bundle passed from the datapath to the controller.
//------------------------------------------------------------------------------
`default_nettype none

package gte_pkg;

    localparam int MAX_NODES = 32;
    localparam int SLOTS     = 32;
    localparam int NW        = 5;               // node index width
    localparam int CW        = NW + 1;          // count width, holds SLOTS itself
    localparam int ENTRY_W   = NW + CW;         // walk store entry: resume index, vertex

    localparam logic [CW-1:0] CAPACITY_C =
        CW'((MAX_NODES < SLOTS) ? MAX_NODES : SLOTS);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    localparam logic [1:0] CMD_ADD_NODE = 2'd0;
    localparam logic [1:0] CMD_ADD_EDGE = 2'd1;
    localparam logic [1:0] CMD_DFS      = 2'd2;
    localparam logic [1:0] CMD_BFS      = 2'd3;

    localparam logic [1:0] ST_ACK       = 2'd0;
    localparam logic [1:0] ST_VISIT     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE      = 4'd0;
    localparam op_t OP_ACCEPT    = 4'd1;
    localparam op_t OP_SINGLE    = 4'd2;
    localparam op_t OP_EDGE1     = 4'd3;
    localparam op_t OP_EDGE2     = 4'd4;
    localparam op_t OP_WALK_INIT = 4'd5;
    localparam op_t OP_DFS_LOAD  = 4'd6;
    localparam op_t OP_DFS_SCAN  = 4'd7;
    localparam op_t OP_DFS_PUSH  = 4'd8;
    localparam op_t OP_DFS_POP   = 4'd9;
    localparam op_t OP_BFS_POP   = 4'd10;
    localparam op_t OP_BFS_RD    = 4'd11;
    localparam op_t OP_BFS_CHK   = 4'd12;
    localparam op_t OP_FINISH    = 4'd13;

    typedef struct packed {
        logic       out_free;
        logic       pend_valid;
        logic [1:0] cmd;
        logic       a_ok;
        logic       edge_new;
        logic       dfs_skip;
        logic       dfs_push;
        logic       sp_one;
        logic       bfs_empty;
        logic       bfs_has;
        logic       bfs_more;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/graph_traversal_engine.sv -----
// Add node, add edge: the result beat loads in S_DECIDE, or S_EDGE2 for a new edge.
// A walk emits one beat per visited vertex; a depth-first walk examines one adjacency
// bit per cycle (a push waits while the output register is held), a breadth-first
// walk does one list memory read per neighbor list entry.
// One command is in flight at a time; the output register lets the next be accepted.
// Reset clears the node count, controller and output valid; the graph is then empty.
//------------------------------------------------------------------------------
// graph_traversal_engine
// Undirected graph store with add node, add edge, depth-first and breadth-first
// walk commands.
//------------------------------------------------------------------------------
`default_nettype none

module graph_traversal_engine
    import gte_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    command,
    input  wire logic [NW-1:0] node_a,
    input  wire logic [NW-1:0] node_b,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [NW-1:0]      vertex,
    output logic [1:0]         status,
    output logic               last
);

    op_t        op;
    dp_status_t st;

    gte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .op       (op)
    );

    gte_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .command   (command),
        .node_a    (node_a),
        .node_b    (node_b),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .vertex    (vertex),
        .status    (status),
        .last      (last),
        .st        (st)
    );

endmodule

`default_nettype wire

// ----- sv/gte_dp.sv -----
//------------------------------------------------------------------------------
// gte_dp
// Datapath: graph storage, walk store, visited marks, pending result and the
// output register. Carries out one operation per cycle from the controller.
//------------------------------------------------------------------------------
`default_nettype none

module gte_dp
    import gte_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire op_t           op,
    input  wire logic [1:0]    command,
    input  wire logic [NW-1:0] node_a,
    input  wire logic [NW-1:0] node_b,
    input  wire logic          out_stall,
    output logic               out_valid,
    output logic [NW-1:0]      vertex,
    output logic [1:0]         status,
    output logic               last,
    output dp_status_t         st
);

    logic [CW-1:0]      cnt_reg;
    logic [SLOTS-1:0]   adj_reg [SLOTS];
    logic [CW-1:0]      len_reg [SLOTS];
    logic [NW-1:0]      nbr_mem [SLOTS*SLOTS];
    logic [NW-1:0]      rd_reg;
    logic [SLOTS-1:0]   vis_reg;
    logic [ENTRY_W-1:0] stk_reg [SLOTS];
    logic [CW-1:0]      sp_reg, head_reg, tail_reg, n_reg, idx_reg;
    logic [NW-1:0]      cv_reg, pend_reg;
    logic [1:0]         cmd_reg;
    logic [NW-1:0]      a_reg, b_reg;
    logic               pend_v_reg, out_valid_reg;
    logic [NW-1:0]      vertex_reg;
    logic [1:0]         status_reg;
    logic               last_reg;

    logic               a_ok, b_ok, idx_lt, out_free, out_load;
    logic [NW-1:0]      idx5, sp_m1, hv, sv;
    logic [1:0]         ss;
    logic               add_new;
    logic [ENTRY_W-1:0] top;
    logic               app_en;
    logic [NW-1:0]      app_v, app_w;
    logic [CW-1:0]      app_len;
    logic [SLOTS-1:0]   adj_row;

    assign a_ok     = {1'b0, a_reg} < cnt_reg;
    assign b_ok     = {1'b0, b_reg} < cnt_reg;
    assign idx5     = idx_reg[NW-1:0];
    assign idx_lt   = idx_reg < cnt_reg;
    assign sp_m1    = NW'(sp_reg - CW'(1));
    assign top      = stk_reg[sp_m1];
    assign hv       = stk_reg[head_reg[NW-1:0]][NW-1:0];
    assign adj_row  = adj_reg[cv_reg];
    assign out_free = !out_valid_reg || !out_stall;

    // Single-beat answers for add node, add edge and a walk with a bad start.
    always_comb
    begin
        sv      = a_reg;
        ss      = ST_ACK;
        add_new = 1'b0;
        unique case (cmd_reg)
            CMD_ADD_NODE:
            begin
                if (a_ok)
                begin
                    ss = ST_ACK;
                end
                else if (cnt_reg >= CAPACITY_C)
                begin
                    sv = '0;
                    ss = ST_FULL;
                end
                else if ({1'b0, a_reg} == cnt_reg)
                begin
                    add_new = 1'b1;
                end
                else
                begin
                    sv = '0;
                    ss = ST_NOT_FOUND;
                end
            end
            CMD_ADD_EDGE:
            begin
                if (!(a_ok && b_ok))
                begin
                    sv = '0;
                    ss = ST_NOT_FOUND;
                end
            end
            default:
            begin
                sv = '0;
                ss = ST_NOT_FOUND;
            end
        endcase
    end

    assign app_en  = (op == OP_EDGE1) || ((op == OP_EDGE2) && (a_reg != b_reg));
    assign app_v   = (op == OP_EDGE1) ? a_reg : b_reg;
    assign app_w   = (op == OP_EDGE1) ? b_reg : a_reg;
    assign app_len = len_reg[app_v];

    assign out_load = (op == OP_SINGLE) || (op == OP_EDGE2) || (op == OP_FINISH) ||
                      (((op == OP_DFS_PUSH) || (op == OP_BFS_POP)) && pend_v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if ((op == OP_SINGLE) && add_new)
                cnt_reg <= CW'(cnt_reg + CW'(1));
            if (op == OP_WALK_INIT)
                pend_v_reg <= (cmd_reg == CMD_DFS);
            else if (op == OP_BFS_POP)
                pend_v_reg <= 1'b1;
            else if (op == OP_FINISH)
                pend_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (app_en && !app_len[CW-1])
            nbr_mem[{app_v, app_len[NW-1:0]}] <= app_w;
        if (op == OP_BFS_RD)
            rd_reg <= nbr_mem[{cv_reg, idx5}];
    end

    always_ff @(posedge clk)
    begin
        if (app_en && !app_len[CW-1])
            len_reg[app_v] <= CW'(app_len + CW'(1));
        if (out_load && pend_v_reg && (op != OP_FINISH))
        begin
            vertex_reg <= pend_reg;
            status_reg <= ST_VISIT;
            last_reg   <= 1'b0;
        end
        unique case (op)
            OP_ACCEPT:
            begin
                cmd_reg <= command;
                a_reg   <= node_a;
                b_reg   <= node_b;
            end
            OP_SINGLE:
            begin
                vertex_reg <= sv;
                status_reg <= ss;
                last_reg   <= 1'b1;
                if (add_new)
                begin
                    adj_reg[a_reg] <= '0;
                    len_reg[a_reg] <= '0;
                end
            end
            OP_EDGE1:
                adj_reg[a_reg][b_reg] <= 1'b1;
            OP_EDGE2:
            begin
                adj_reg[b_reg][a_reg] <= 1'b1;
                vertex_reg <= a_reg;
                status_reg <= ST_ACK;
                last_reg   <= 1'b1;
            end
            OP_WALK_INIT:
            begin
                vis_reg    <= SLOTS'(1) << a_reg;
                stk_reg[0] <= {CW'(0), a_reg};
                sp_reg     <= CW'(1);
                n_reg      <= CW'(1);
                head_reg   <= '0;
                tail_reg   <= CW'(1);
                pend_reg   <= a_reg;
            end
            OP_DFS_LOAD:
            begin
                cv_reg  <= top[NW-1:0];
                idx_reg <= top[ENTRY_W-1:NW];
            end
            OP_DFS_SCAN:
                idx_reg <= CW'(idx_reg + CW'(1));
            OP_DFS_PUSH:
            begin
                stk_reg[sp_m1]            <= {CW'(idx_reg + CW'(1)), cv_reg};
                stk_reg[sp_reg[NW-1:0]]   <= {CW'(0), idx5};
                vis_reg[idx5]             <= 1'b1;
                pend_reg                  <= idx5;
                sp_reg                    <= CW'(sp_reg + CW'(1));
                n_reg                     <= CW'(n_reg + CW'(1));
                cv_reg                    <= idx5;
                idx_reg                   <= '0;
            end
            OP_DFS_POP:
                sp_reg <= CW'(sp_reg - CW'(1));
            OP_BFS_POP:
            begin
                head_reg <= CW'(head_reg + CW'(1));
                pend_reg <= hv;
                cv_reg   <= hv;
                idx_reg  <= '0;
            end
            OP_BFS_CHK:
            begin
                if (!vis_reg[rd_reg] && (tail_reg < SLOTS_C))
                begin
                    vis_reg[rd_reg]             <= 1'b1;
                    stk_reg[tail_reg[NW-1:0]]   <= {CW'(0), rd_reg};
                    tail_reg                    <= CW'(tail_reg + CW'(1));
                end
                idx_reg <= CW'(idx_reg + CW'(1));
            end
            OP_FINISH:
            begin
                vertex_reg <= pend_reg;
                status_reg <= ST_VISIT;
                last_reg   <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        st.out_free   = out_free;
        st.pend_valid = pend_v_reg;
        st.cmd        = cmd_reg;
        st.a_ok       = a_ok;
        st.edge_new   = a_ok && b_ok && !adj_reg[a_reg][b_reg];
        st.dfs_skip   = idx_lt && ((idx5 == cv_reg) || !adj_row[idx5] || vis_reg[idx5]);
        st.dfs_push   = idx_lt && !st.dfs_skip && (sp_reg < SLOTS_C) && (n_reg < SLOTS_C);
        st.sp_one     = (sp_reg == CW'(1));
        st.bfs_empty  = (head_reg == tail_reg);
        st.bfs_has    = (len_reg[hv] != '0);
        st.bfs_more   = CW'(idx_reg + CW'(1)) < len_reg[cv_reg];
    end

    assign out_valid = out_valid_reg;
    assign vertex    = vertex_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ----- sv/gte_ctrl.sv -----
//------------------------------------------------------------------------------
// gte_ctrl
// Controller: sequences each command into datapath operations and holds off
// result writes while the output register is occupied.
//------------------------------------------------------------------------------
`default_nettype none

module gte_ctrl
    import gte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t st,
    output op_t             op
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_EDGE2  = 4'd2;
    localparam logic [3:0] S_DLOAD  = 4'd3;
    localparam logic [3:0] S_DSCAN  = 4'd4;
    localparam logic [3:0] S_BPOP   = 4'd5;
    localparam logic [3:0] S_BRD    = 4'd6;
    localparam logic [3:0] S_BCHK   = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_ACCEPT;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if ((st.cmd == CMD_ADD_EDGE) && st.edge_new)
                begin
                    op         = OP_EDGE1;
                    state_next = S_EDGE2;
                end
                else if (((st.cmd == CMD_DFS) || (st.cmd == CMD_BFS)) && st.a_ok)
                begin
                    op         = OP_WALK_INIT;
                    state_next = (st.cmd == CMD_DFS) ? S_DLOAD : S_BPOP;
                end
                else if (st.out_free)
                begin
                    op         = OP_SINGLE;
                    state_next = S_IDLE;
                end
            end
            S_EDGE2:
            begin
                if (st.out_free)
                begin
                    op         = OP_EDGE2;
                    state_next = S_IDLE;
                end
            end
            S_DLOAD:
            begin
                op         = OP_DFS_LOAD;
                state_next = S_DSCAN;
            end
            S_DSCAN:
            begin
                priority if (st.dfs_skip)
                begin
                    op = OP_DFS_SCAN;
                end
                else if (st.dfs_push)
                begin
                    if (st.out_free)
                        op = OP_DFS_PUSH;
                end
                else
                begin
                    op         = OP_DFS_POP;
                    state_next = st.sp_one ? S_FIN : S_DLOAD;
                end
            end
            S_BPOP:
            begin
                priority if (st.bfs_empty)
                begin
                    state_next = S_FIN;
                end
                else if (st.out_free || !st.pend_valid)
                begin
                    op         = OP_BFS_POP;
                    state_next = st.bfs_has ? S_BRD : S_BPOP;
                end
            end
            S_BRD:
            begin
                op         = OP_BFS_RD;
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                op         = OP_BFS_CHK;
                state_next = st.bfs_more ? S_BRD : S_BPOP;
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    op         = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- sv/gte_chk.sv -----
//------------------------------------------------------------------------------
// gte_chk
// Port-level checks on the traversal engine, attached by bind.
//------------------------------------------------------------------------------
`default_nettype none

module gte_chk
    import gte_pkg::*;
(
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_stall,
    input wire logic          out_valid,
    input wire logic          out_stall,
    input wire logic [NW-1:0] vertex,
    input wire logic [1:0]    status,
    input wire logic          last
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vertex) && $stable(status)
        && $stable(last))
        else $error("stalled result beat changed");

    // One command at a time: the input stalls right after a beat is taken.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second command accepted while busy");

    // Acknowledge and error answers are single beats.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_VISIT) |-> last)
        else $error("non-visit result not flagged last");

    a_err_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == ST_FULL) || (status == ST_NOT_FOUND)) |-> vertex == '0)
        else $error("error result carries a vertex");

endmodule

bind graph_traversal_engine gte_chk u_gte_chk (.*);

`default_nettype wire

// ----- sim/tb_graph_traversal_engine.sv -----
//------------------------------------------------------------------------------
// tb_graph_traversal_engine
// Drives add node, add edge and depth-first / breadth-first walk commands into
// the graph engine, predicts every reply beat in the testbench and compares
// each delivered beat in order. Stalls and gaps vary per phase; the receiver
// holds off once long enough to back the engine up.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_graph_traversal_engine;
    import gte_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int GRAPH_SLOTS = 32;

    typedef struct {
        logic [4:0] vtx;
        logic [1:0] st;
        logic       fin;
    } reply_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] command = CMD_ADD_NODE;
    logic [4:0] node_a = '0;
    logic [4:0] node_b = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [4:0] vertex;
    logic [1:0] status;
    logic       last;

    // Shadow copy of the graph held by the engine.
    int          nodes_held;
    logic [31:0] adj_rows [GRAPH_SLOTS];
    logic [4:0]  nbr_list [GRAPH_SLOTS][GRAPH_SLOTS];
    int          nbr_len  [GRAPH_SLOTS];

    reply_t expected_replies [$];
    int     mismatches = 0;
    int     send_gap_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_left = 0;
    int     quiet_cycles = 0;

    graph_traversal_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .node_a    (node_a),
        .node_b    (node_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .vertex    (vertex),
        .status    (status),
        .last      (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic reply_t mk_reply(logic [4:0] v, logic [1:0] s, logic f);
        reply_t r;
        r.vtx = v;
        r.st  = s;
        r.fin = f;
        return r;
    endfunction

    function automatic void queue_reply(reply_t r);
        expected_replies.insert(expected_replies.size(), r);
    endfunction

    function automatic void add_to_list(int v, int w);
        if (nbr_len[v] < GRAPH_SLOTS)
        begin
            nbr_list[v][nbr_len[v]] = w[4:0];
            nbr_len[v]++;
        end
    endfunction

    // Works out the reply beats for one accepted command and updates the graph.
    function automatic void predict_replies(logic [1:0] cmd, logic [4:0] a, logic [4:0] b);
        reply_t      walk [$];
        logic [31:0] seen;
        logic [4:0]  stk_v [GRAPH_SLOTS];
        int          stk_i [GRAPH_SLOTS];
        logic [4:0]  fifo [GRAPH_SLOTS];
        int          sp, i, head, tail;
        logic [4:0]  v, w;
        if (cmd == CMD_ADD_NODE)
        begin
            if (a < nodes_held)
                queue_reply(mk_reply(a, ST_ACK, 1'b1));
            else if (nodes_held >= int'(CAPACITY_C))
                queue_reply(mk_reply(5'd0, ST_FULL, 1'b1));
            else if (a == nodes_held)
            begin
                adj_rows[a] = '0;
                nbr_len[a] = 0;
                nodes_held++;
                queue_reply(mk_reply(a, ST_ACK, 1'b1));
            end
            else
                queue_reply(mk_reply(5'd0, ST_NOT_FOUND, 1'b1));
            return;
        end
        if (cmd == CMD_ADD_EDGE)
        begin
            if (a >= nodes_held || b >= nodes_held)
            begin
                queue_reply(mk_reply(5'd0, ST_NOT_FOUND, 1'b1));
                return;
            end
            if (!adj_rows[a][b])
            begin
                adj_rows[a][b] = 1'b1;
                adj_rows[b][a] = 1'b1;
                add_to_list(a, b);
                if (a != b)
                    add_to_list(b, a);
            end
            queue_reply(mk_reply(a, ST_ACK, 1'b1));
            return;
        end
        if (a >= nodes_held)
        begin
            queue_reply(mk_reply(5'd0, ST_NOT_FOUND, 1'b1));
            return;
        end
        seen = '0;
        seen[a] = 1'b1;
        if (cmd == CMD_DFS)
        begin
            walk.insert(walk.size(), mk_reply(a, ST_VISIT, 1'b0));
            stk_v[0] = a;
            stk_i[0] = 0;
            sp = 1;
            while (sp > 0)
            begin
                v = stk_v[sp-1];
                i = stk_i[sp-1];
                while (i < nodes_held && (i == v || !adj_rows[v][i] || seen[i]))
                    i++;
                if (i < nodes_held && sp < GRAPH_SLOTS && walk.size() < GRAPH_SLOTS)
                begin
                    stk_i[sp-1] = i + 1;
                    seen[i] = 1'b1;
                    walk.insert(walk.size(), mk_reply(i[4:0], ST_VISIT, 1'b0));
                    stk_v[sp] = i[4:0];
                    stk_i[sp] = 0;
                    sp++;
                end
                else
                    sp--;
            end
        end
        else
        begin
            fifo[0] = a;
            head = 0;
            tail = 1;
            while (head < tail)
            begin
                v = fifo[head];
                head++;
                walk.insert(walk.size(), mk_reply(v, ST_VISIT, 1'b0));
                for (i = 0; i < nbr_len[v]; i++)
                begin
                    w = nbr_list[v][i];
                    if (!seen[w] && tail < GRAPH_SLOTS)
                    begin
                        seen[w] = 1'b1;
                        fifo[tail] = w;
                        tail++;
                    end
                end
            end
        end
        walk[walk.size()-1].fin = 1'b1;
        foreach (walk[k])
            queue_reply(walk[k]);
    endfunction

    // Offers one command and returns at the edge where it is taken; valid stays high.
    task automatic send_command(logic [1:0] cmd, logic [4:0] a, logic [4:0] b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        node_a   <= a;
        node_b   <= b;
        do
            @(posedge clk);
        while (in_stall);
        predict_replies(cmd, a, b);
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_command();
        int          r;
        logic [4:0]  a, b;
        logic [1:0]  cmd;
        r = $urandom_range(99);
        a = 5'($urandom_range(31));
        b = 5'($urandom_range(31));
        if (nodes_held > 0 && $urandom_range(9) != 0)
        begin
            a = 5'($urandom_range(nodes_held - 1));
            b = 5'($urandom_range(nodes_held - 1));
        end
        if (r < 15)
        begin
            cmd = CMD_ADD_NODE;
            if ($urandom_range(3) != 0 && nodes_held < GRAPH_SLOTS)
                a = nodes_held[4:0];
        end
        else if (r < 60)
            cmd = CMD_ADD_EDGE;
        else if (r < 80)
            cmd = CMD_DFS;
        else
            cmd = CMD_BFS;
        send_command(cmd, a, b);
    endtask

    task automatic test_directed();
        send_command(CMD_DFS, 5'd0, 5'd31);
        send_command(CMD_BFS, 5'd31, 5'd0);
        send_command(CMD_ADD_NODE, 5'd3, 5'd0);     // skips an index
        send_command(CMD_ADD_EDGE, 5'd0, 5'd0);     // no such endpoint yet
        send_command(CMD_ADD_NODE, 5'd0, 5'd31);
        send_command(CMD_ADD_NODE, 5'd0, 5'd0);     // already there
        send_command(CMD_DFS, 5'd0, 5'd0);
        send_command(CMD_ADD_EDGE, 5'd0, 5'd0);     // self loop
        send_command(CMD_BFS, 5'd0, 5'd0);
        send_command(CMD_ADD_NODE, 5'd1, 5'd0);
        send_command(CMD_ADD_NODE, 5'd2, 5'd0);
        send_command(CMD_ADD_NODE, 5'd3, 5'd0);
        send_command(CMD_ADD_EDGE, 5'd0, 5'd31);    // second end unknown
        send_command(CMD_ADD_EDGE, 5'd2, 5'd0);
        send_command(CMD_ADD_EDGE, 5'd3, 5'd1);
        send_command(CMD_ADD_EDGE, 5'd0, 5'd3);
        send_command(CMD_ADD_EDGE, 5'd1, 5'd3);     // repeated edge
        send_command(CMD_ADD_EDGE, 5'd0, 5'd2);     // repeated, reversed
        send_command(CMD_DFS, 5'd0, 5'd0);
        send_command(CMD_BFS, 5'd0, 5'd0);
        send_command(CMD_DFS, 5'd1, 5'd0);
        send_command(CMD_BFS, 5'd2, 5'd0);
        send_command(CMD_DFS, 5'd4, 5'd0);          // start not in graph
        drain_replies();
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_random_command();
        drain_replies();
    endtask

    // Receiver holds off as the graph starts to fill to capacity, so the sender waits.
    task automatic test_fill_under_backpressure();
        hold_left = 300;
        while (nodes_held < GRAPH_SLOTS)
            send_command(CMD_ADD_NODE, nodes_held[4:0], 5'd0);
        send_command(CMD_ADD_NODE, 5'd31, 5'd31);   // graph full, but node 31 exists
        send_command(CMD_ADD_NODE, 5'd31, 5'd0);    // last slot exists
        send_command(CMD_ADD_EDGE, 5'd31, 5'd0);
        send_command(CMD_ADD_EDGE, 5'd0, 5'd31);
        send_command(CMD_BFS, 5'd31, 5'd0);
        drain_replies();
    endtask

    always @(posedge clk)
    begin
        reply_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected beat: vertex %0d status %0d last %0d",
                             vertex, status, last);
            end
            else
            begin
                exp_r = expected_replies.pop_front();
                if (vertex !== exp_r.vtx || status !== exp_r.st || last !== exp_r.fin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected vertex %0d status %0d last %0d, ",
                                  "got %0d %0d %0d"},
                                 exp_r.vtx, exp_r.st, exp_r.fin, vertex, status, last);
                end
            end
        end
    end

    // Receiver stall; a long hold is counted down here cycle by cycle.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        nodes_held = 0;
        foreach (adj_rows[k])
        begin
            adj_rows[k] = '0;
            nbr_len[k] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 11;
        recv_stall_pct = 54;
        test_directed();
        test_random(65);
        test_fill_under_backpressure();

        send_gap_pct = 54;
        recv_stall_pct = 11;
        test_random(70);

        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random(70);

        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
